[rtl/bfd_pkg.sv]
package bfd_pkg;

   localparam int MAX_SOURCE_DIM = 8192;
   localparam int MAX_TARGET_DIM = 128;
   localparam int CHANNELS       = 4;
   localparam int PIX_W          = 8;
   localparam int COORD_W        = 7;
   localparam int SRC_REG_W      = 14;
   localparam int TGT_REG_W      = 8;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 14;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_HEIGHT = 3'd3;

   // entry select: bit 1 row, bit 0 column; 0 = window before the top one, 1 = top
   localparam logic [1:0] SEL_LAST = 2'b11;

   typedef struct packed {
      logic [PIX_W-1:0] in_red;
      logic [PIX_W-1:0] in_green;
      logic [PIX_W-1:0] in_blue;
      logic [PIX_W-1:0] in_alpha;
   } pixel_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_column;
      logic [COORD_W-1:0] out_row;
      logic [PIX_W-1:0]   out_red;
      logic [PIX_W-1:0]   out_green;
      logic [PIX_W-1:0]   out_blue;
      logic [PIX_W-1:0]   out_alpha;
      logic               run_end;
   } result_type;

   typedef struct packed {
      logic       load;
      logic       read;
      logic       acc;
      logic       div;
      logic       step;
      logic [1:0] sel;
      logic       run_end;
   } command_type;

   typedef struct packed {
      logic init_busy;
      logic shared_row;
      logic shared_col;
      logic last_row;
      logic last_col;
      logic div_done;
   } status_type;

   function automatic logic entry_valid(logic [1:0] sel, logic shared_row, logic shared_col);
      return (sel[1] | shared_row) & (sel[0] | shared_col);
   endfunction

   function automatic logic entry_emits(logic [1:0] sel, logic last_row, logic last_col);
      return (~sel[1] | last_row) & (~sel[0] | last_col);
   endfunction

   function automatic logic later_emits(logic [1:0] sel, status_type st);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (2'(i) > sel && entry_valid(2'(i), st.shared_row, st.shared_col)
             && entry_emits(2'(i), st.last_row, st.last_col)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

[rtl/bfd_ram.sv]
module bfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bfd_axis.sv]
// Tracks the source position along one axis and the destination window(s) that
// hold it. a_ff = (top+1)*size, b_ff = (pos+1)*target; the top window advances
// when a_ff < b_ff, which is the exact form of floor((top+1)*size/target) <= pos.
module bfd_axis #(
   parameter int MAX_SRC = bfd_pkg::MAX_SOURCE_DIM,
   parameter int MAX_TGT = bfd_pkg::MAX_TARGET_DIM,
   localparam int SW_W  = $clog2(MAX_SRC + 1),
   localparam int TW_W  = $clog2(MAX_TGT + 1),
   localparam int TOP_W = (MAX_TGT > 1) ? $clog2(MAX_TGT) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             init,
   input  logic             step,
   input  logic [SW_W-1:0]  size,
   input  logic [TW_W-1:0]  target,
   output logic [TOP_W-1:0] top,
   output logic             adv,
   output logic             last
);

   localparam int POS_W = (MAX_SRC > 1) ? $clog2(MAX_SRC) : 1;
   localparam int PW    = $clog2(MAX_SRC * MAX_TGT + 1) + 1;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [TOP_W-1:0] top_ff, top_in;
   logic [PW-1:0]    a_ff, a_in;
   logic [PW-1:0]    b_ff, b_in;
   logic             adv_ff, adv_in;
   logic [PW-1:0]    b_next;
   logic             pos_last;

   assign pos_last = (SW_W'(pos_ff) == size - 1'b1);
   assign b_next   = b_ff + PW'(target);

   always_comb begin
      pos_in = pos_ff;
      top_in = top_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      adv_in = adv_ff;
      if (reset || init || (step && pos_last)) begin
         pos_in = '0;
         top_in = '0;
         a_in   = PW'(size);
         b_in   = PW'(target);
         adv_in = 1'b1;
      end else if (step) begin
         pos_in = pos_ff + 1'b1;
         b_in   = b_next;
         if (a_ff < b_next) begin
            top_in = top_ff + 1'b1;
            a_in   = a_ff + PW'(size);
            adv_in = 1'b1;
         end else begin
            adv_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      top_ff <= top_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      adv_ff <= adv_in;
   end

   assign top  = top_ff;
   assign adv  = adv_ff;
   assign last = pos_last;

endmodule

[rtl/bfd_datapath.sv]
module bfd_datapath #(
   parameter int MAX_SOURCE_DIM = bfd_pkg::MAX_SOURCE_DIM,
   parameter int MAX_TARGET_DIM = bfd_pkg::MAX_TARGET_DIM
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bfd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  bfd_pkg::pixel_type               req_data,
   input  bfd_pkg::command_type             cmd,
   output bfd_pkg::status_type              status,
   output bfd_pkg::result_type              rsp_data
);

   localparam int SW_W   = $clog2(MAX_SOURCE_DIM + 1);
   localparam int TW_W   = $clog2(MAX_TARGET_DIM + 1);
   localparam int TOP_W  = (MAX_TARGET_DIM > 1) ? $clog2(MAX_TARGET_DIM) : 1;
   localparam int CNT_W  = 2 * SW_W;
   localparam int SUM_W  = CNT_W + bfd_pkg::PIX_W;
   localparam int NCH    = bfd_pkg::CHANNELS;
   localparam int WORD_W = NCH * SUM_W + CNT_W;
   localparam int DEPTH  = 2 * MAX_TARGET_DIM;
   localparam int AW     = $clog2(DEPTH);

   // configuration
   logic [bfd_pkg::SRC_REG_W-1:0] src_w_ff, src_h_ff;
   logic [bfd_pkg::TGT_REG_W-1:0] tgt_w_ff, tgt_h_ff;
   logic                          init_ff;
   logic                          csr_hit;

   assign csr_hit = csr_wr_en && (csr_index == bfd_pkg::REG_SOURCE_WIDTH
                                  || csr_index == bfd_pkg::REG_SOURCE_HEIGHT
                                  || csr_index == bfd_pkg::REG_TARGET_WIDTH
                                  || csr_index == bfd_pkg::REG_TARGET_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= bfd_pkg::SRC_REG_W'(1);
         src_h_ff <= bfd_pkg::SRC_REG_W'(1);
         tgt_w_ff <= bfd_pkg::TGT_REG_W'(1);
         tgt_h_ff <= bfd_pkg::TGT_REG_W'(1);
         init_ff  <= 1'b1;
      end else begin
         init_ff <= csr_hit;
         if (csr_wr_en) begin
            case (csr_index)
               bfd_pkg::REG_SOURCE_WIDTH:  src_w_ff <= csr_wdata[bfd_pkg::SRC_REG_W-1:0];
               bfd_pkg::REG_SOURCE_HEIGHT: src_h_ff <= csr_wdata[bfd_pkg::SRC_REG_W-1:0];
               bfd_pkg::REG_TARGET_WIDTH:  tgt_w_ff <= csr_wdata[bfd_pkg::TGT_REG_W-1:0];
               bfd_pkg::REG_TARGET_HEIGHT: tgt_h_ff <= csr_wdata[bfd_pkg::TGT_REG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // clamped sizes
   logic [SW_W-1:0] size_w, size_h, lim_w, lim_h;
   logic [TW_W-1:0] targ_w, targ_h;

   always_comb begin
      if (src_w_ff == '0)                 size_w = SW_W'(1);
      else if (src_w_ff > MAX_SOURCE_DIM) size_w = SW_W'(MAX_SOURCE_DIM);
      else                                size_w = SW_W'(src_w_ff);
      if (src_h_ff == '0)                 size_h = SW_W'(1);
      else if (src_h_ff > MAX_SOURCE_DIM) size_h = SW_W'(MAX_SOURCE_DIM);
      else                                size_h = SW_W'(src_h_ff);
      lim_w = (size_w < SW_W'(MAX_TARGET_DIM)) ? size_w : SW_W'(MAX_TARGET_DIM);
      lim_h = (size_h < SW_W'(MAX_TARGET_DIM)) ? size_h : SW_W'(MAX_TARGET_DIM);
      if (tgt_w_ff == '0)                 targ_w = TW_W'(1);
      else if (SW_W'(tgt_w_ff) > lim_w)   targ_w = TW_W'(lim_w);
      else                                targ_w = TW_W'(tgt_w_ff);
      if (tgt_h_ff == '0)                 targ_h = TW_W'(1);
      else if (SW_W'(tgt_h_ff) > lim_h)   targ_h = TW_W'(lim_h);
      else                                targ_h = TW_W'(tgt_h_ff);
   end

   // position trackers
   logic [TOP_W-1:0] col_top, row_top;
   logic             col_adv, row_adv, col_last, row_last;

   bfd_axis #(.MAX_SRC(MAX_SOURCE_DIM), .MAX_TGT(MAX_TARGET_DIM)) u_col (
      .clock  (clock),
      .reset  (reset),
      .init   (init_ff),
      .step   (cmd.step),
      .size   (size_w),
      .target (targ_w),
      .top    (col_top),
      .adv    (col_adv),
      .last   (col_last)
   );

   bfd_axis #(.MAX_SRC(MAX_SOURCE_DIM), .MAX_TGT(MAX_TARGET_DIM)) u_row (
      .clock  (clock),
      .reset  (reset),
      .init   (init_ff),
      .step   (cmd.step && col_last),
      .size   (size_h),
      .target (targ_h),
      .top    (row_top),
      .adv    (row_adv),
      .last   (row_last)
   );

   // current entry
   logic [TOP_W-1:0] dc, dr;
   logic [AW-1:0]    addr;
   logic             first;

   assign dc    = cmd.sel[0] ? col_top : col_top - 1'b1;
   assign dr    = cmd.sel[1] ? row_top : row_top - 1'b1;
   assign addr  = dr[0] ? AW'(MAX_TARGET_DIM) + AW'(dc) : AW'(dc);
   assign first = cmd.sel[1] & row_adv & cmd.sel[0] & col_adv;

   // pixel latch
   bfd_pkg::pixel_type         px_ff;
   logic [bfd_pkg::PIX_W-1:0] px_ch [NCH];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= req_data;
      end
   end

   assign px_ch[0] = px_ff.in_red;
   assign px_ch[1] = px_ff.in_green;
   assign px_ch[2] = px_ff.in_blue;
   assign px_ch[3] = px_ff.in_alpha;

   // accumulator memory
   logic [WORD_W-1:0] rd_word, wr_word;
   logic [SUM_W-1:0]  new_sum [NCH];
   logic [CNT_W-1:0]  new_cnt;

   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         new_sum[ch] = first ? SUM_W'(px_ch[ch])
                             : rd_word[CNT_W + ch*SUM_W +: SUM_W] + SUM_W'(px_ch[ch]);
         wr_word[CNT_W + ch*SUM_W +: SUM_W] = new_sum[ch];
      end
      new_cnt = first ? CNT_W'(1) : rd_word[CNT_W-1:0] + 1'b1;
      wr_word[CNT_W-1:0] = new_cnt;
   end

   bfd_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_sums (
      .clock   (clock),
      .wr_en   (cmd.acc),
      .wr_addr (addr),
      .wr_data (wr_word),
      .rd_en   (cmd.read),
      .rd_addr (addr),
      .rd_data (rd_word)
   );

   // restoring divider, one quotient bit per cycle for all channels
   logic [SUM_W-1:0]          rem_ff [NCH];
   logic [bfd_pkg::PIX_W-1:0] q_ff [NCH];
   logic [CNT_W-1:0]          cnt_ff;
   logic [2:0]                bit_ff;
   logic [SUM_W-1:0]          div_shift;
   logic [bfd_pkg::COORD_W-1:0] col_ff, row_ff;
   logic                      run_end_ff;

   assign div_shift = SUM_W'(cnt_ff) << bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.acc) begin
         for (int ch = 0; ch < NCH; ch++) begin
            rem_ff[ch] <= new_sum[ch];
            q_ff[ch]   <= '0;
         end
         cnt_ff     <= new_cnt;
         bit_ff     <= 3'd7;
         col_ff     <= bfd_pkg::COORD_W'(dc);
         row_ff     <= bfd_pkg::COORD_W'(dr);
         run_end_ff <= cmd.run_end;
      end else if (cmd.div) begin
         for (int ch = 0; ch < NCH; ch++) begin
            if (rem_ff[ch] >= div_shift) begin
               rem_ff[ch]       <= rem_ff[ch] - div_shift;
               q_ff[ch][bit_ff] <= 1'b1;
            end
         end
         bit_ff <= bit_ff - 1'b1;
      end
   end

   logic cnt_zero;
   assign cnt_zero = (cnt_ff == '0);

   assign rsp_data.out_column = col_ff;
   assign rsp_data.out_row    = row_ff;
   assign rsp_data.out_red    = cnt_zero ? '0 : q_ff[0];
   assign rsp_data.out_green  = cnt_zero ? '0 : q_ff[1];
   assign rsp_data.out_blue   = cnt_zero ? '0 : q_ff[2];
   assign rsp_data.out_alpha  = cnt_zero ? '0 : q_ff[3];
   assign rsp_data.run_end    = run_end_ff;

   assign status.init_busy  = init_ff;
   assign status.shared_row = row_adv && (row_top != '0);
   assign status.shared_col = col_adv && (col_top != '0);
   assign status.last_row   = row_last;
   assign status.last_col   = col_last;
   assign status.div_done   = (bit_ff == 3'd0);

endmodule

[rtl/bfd_ctrl.sv]
module bfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bfd_pkg::status_type  status,
   output bfd_pkg::command_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_SEND = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [1:0] sel_next;
   logic       emit;

   assign emit     = bfd_pkg::entry_emits(sel_ff, status.last_row, status.last_col);
   // column pair first, then the next row; the column-0 entry exists only if shared
   assign sel_next = sel_ff[0] ? {1'b1, ~status.shared_col} : {sel_ff[1], 1'b1};

   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      cmd         = '0;
      cmd.sel     = sel_ff;
      cmd.run_end = ~bfd_pkg::later_emits(sel_ff, status);
      req_ready   = (state_ff == ST_IDLE) && !status.init_busy;
      rsp_valid   = (state_ff == ST_SEND);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.init_busy) begin
               cmd.load = 1'b1;
               sel_in   = {~status.shared_row, ~status.shared_col};
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (emit) begin
               state_in = ST_DIV;
            end else if (sel_ff == bfd_pkg::SEL_LAST) begin
               cmd.step = 1'b1;
               state_in = ST_IDLE;
            end else begin
               sel_in   = sel_next;
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (status.div_done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (sel_ff == bfd_pkg::SEL_LAST) begin
                  cmd.step = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  sel_in   = sel_next;
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= bfd_pkg::SEL_LAST;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   a_acc_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC |-> $past(state_ff) == ST_READ)
      else $error("accumulate without a preceding memory read");

   a_send_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DIV && status.div_done))
      else $error("result offered before the divider finished");

   a_step_on_last: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> sel_ff == bfd_pkg::SEL_LAST)
      else $error("position advanced before the last window entry");

endmodule

[rtl/rgba_box_filter_downscaler.sv]
// After the accept, a pixel is read and accumulated once per window entry it touches
// (1 or 2 columns by 1 or 2 rows); a closed window adds a divide and an output beat
// that waits for rsp_ready. A new pixel is accepted only once the controller is back
// in idle, after every entry of the previous pixel and any output stall.
// Reset (synchronous, active high) sets all sizes to 1 and the position to the
// frame start; accumulator memory needs no clearing, a window's first pixel overwrites it.
module rgba_box_filter_downscaler #(
   parameter int MAX_SOURCE_DIM = bfd_pkg::MAX_SOURCE_DIM,
   parameter int MAX_TARGET_DIM = bfd_pkg::MAX_TARGET_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bfd_pkg::pixel_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bfd_pkg::result_type             rsp_data,
   input  logic                            csr_wr_en,
   input  logic [bfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bfd_pkg::command_type cmd;
   bfd_pkg::status_type  status;

   bfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bfd_datapath #(
      .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
      .MAX_TARGET_DIM (MAX_TARGET_DIM)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

[dv/tb_rgba_box_filter_downscaler.sv]
`timescale 1ns / 100ps

module tb_rgba_box_filter_downscaler;
   import bfd_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;
   localparam int RANDOM_PIXELS = 460;
   localparam int SETTLE_CYCLES = 64;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   pixel_type              req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   result_type             rsp_data;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rgba_box_filter_downscaler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's configuration and accumulators
   logic [CSR_DATA_W-1:0] size_regs [4];
   int unsigned           src_col;
   int unsigned           src_row;
   longint unsigned       chan_sums [CHANNELS][2*MAX_TARGET_DIM];
   longint unsigned       pix_counts [2*MAX_TARGET_DIM];

   result_type expected_windows [$];
   bit         failed;
   int         burst_left;

   typedef struct {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      pixel_type              px;
      bit                     typed;
      result_type             want;
   } step_row;

   step_row directed_steps [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("rgba_box_filter_downscaler regression: fail");
      $finish;
   end

   function automatic int unsigned clamp_dim(longint unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic int unsigned win_low(int unsigned d, int unsigned s, int unsigned t);
      return int'((longint'(d) * s) / t);
   endfunction

   function automatic int unsigned win_high(int unsigned d, int unsigned s, int unsigned t);
      longint unsigned e;
      e = ((longint'(d) + 1) * s) / t;
      return (e > s - 1) ? s - 1 : int'(e);
   endfunction

   // windows (at most two, ascending) that contain source position p
   function automatic int windows_at(int unsigned p, int unsigned s, int unsigned t,
                                     output int unsigned lst [2]);
      longint unsigned top;
      int              n;
      n = 0;
      top = ((longint'(p) + 1) * t - 1) / s;
      if (top >= t) top = t - 1;
      if (top >= 1 && win_high(int'(top) - 1, s, t) >= p) begin
         lst[n] = int'(top) - 1;
         n++;
      end
      lst[n] = int'(top);
      return n + 1;
   endfunction

   function automatic logic [PIX_W-1:0] mean8(longint unsigned sum, longint unsigned cnt);
      if (cnt == 0) return '0;
      return PIX_W'(sum / cnt);
   endfunction

   function automatic void accumulate_pixel(pixel_type px, bit keep);
      int unsigned     sw, sh, dw, dh, dr, dc, idx;
      int unsigned     cols [2];
      int unsigned     rows [2];
      int              nc, nr, emitted;
      bit              row_first, row_last;
      longint unsigned ch [CHANNELS];
      result_type      win;
      result_type      closed [$];

      sw = clamp_dim(size_regs[REG_SOURCE_WIDTH], MAX_SOURCE_DIM);
      sh = clamp_dim(size_regs[REG_SOURCE_HEIGHT], MAX_SOURCE_DIM);
      dw = clamp_dim(size_regs[REG_TARGET_WIDTH], (sw < MAX_TARGET_DIM) ? sw : MAX_TARGET_DIM);
      dh = clamp_dim(size_regs[REG_TARGET_HEIGHT], (sh < MAX_TARGET_DIM) ? sh : MAX_TARGET_DIM);
      ch[0] = px.in_red;
      ch[1] = px.in_green;
      ch[2] = px.in_blue;
      ch[3] = px.in_alpha;
      if (src_col >= sw || src_row >= sh) begin
         src_col = 0;
         src_row = 0;
      end
      nc = windows_at(src_col, sw, dw, cols);
      nr = windows_at(src_row, sh, dh, rows);
      emitted = 0;
      for (int r = 0; r < nr; r++) begin
         dr = rows[r];
         row_first = (src_row == win_low(dr, sh, dh));
         row_last  = (src_row == win_high(dr, sh, dh));
         for (int c = 0; c < nc; c++) begin
            dc  = cols[c];
            idx = (dr % 2) * MAX_TARGET_DIM + dc;
            if (row_first && src_col == win_low(dc, sw, dw)) begin
               for (int k = 0; k < CHANNELS; k++) chan_sums[k][idx] = ch[k];
               pix_counts[idx] = 1;
            end else begin
               for (int k = 0; k < CHANNELS; k++) chan_sums[k][idx] += ch[k];
               pix_counts[idx] += 1;
            end
            if (row_last && src_col == win_high(dc, sw, dw) && emitted < 4) begin
               win.out_column = dc[COORD_W-1:0];
               win.out_row    = dr[COORD_W-1:0];
               win.out_red    = mean8(chan_sums[0][idx], pix_counts[idx]);
               win.out_green  = mean8(chan_sums[1][idx], pix_counts[idx]);
               win.out_blue   = mean8(chan_sums[2][idx], pix_counts[idx]);
               win.out_alpha  = mean8(chan_sums[3][idx], pix_counts[idx]);
               win.run_end    = 1'b0;
               closed.push_back(win);
               emitted++;
            end
         end
      end
      if (closed.size() > 0) closed[closed.size()-1].run_end = 1'b1;
      if (keep) foreach (closed[i]) expected_windows.push_back(closed[i]);
      src_col++;
      if (src_col >= sw) begin
         src_col = 0;
         src_row++;
         if (src_row >= sh) src_row = 0;
      end
   endfunction

   task automatic send_pixel(pixel_type px, bit keep);
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      accumulate_pixel(px, keep);
      burst_left--;
   endtask

   // wait out all windows, then pixels that close none may still be in flight
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_windows.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (index <= REG_TARGET_HEIGHT) begin
         size_regs[index] = (index < REG_TARGET_WIDTH) ? value : value & 14'h00FF;
         src_col = 0;
         src_row = 0;
      end
   endtask

   task automatic configure(int unsigned sw, int unsigned sh, int unsigned dw,
                            int unsigned dh);
      settle();
      write_reg(REG_SOURCE_WIDTH, CSR_DATA_W'(sw));
      write_reg(REG_SOURCE_HEIGHT, CSR_DATA_W'(sh));
      write_reg(REG_TARGET_WIDTH, CSR_DATA_W'(dw));
      write_reg(REG_TARGET_HEIGHT, CSR_DATA_W'(dh));
   endtask

   function automatic void add_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      step_row s;
      s = '{default: '0};
      s.is_write = 1'b1;
      s.index    = index;
      s.value    = value;
      directed_steps.push_back(s);
   endfunction

   function automatic void add_pixel(logic [31:0] rgba);
      step_row s;
      s = '{default: '0};
      s.px = rgba;
      directed_steps.push_back(s);
   endfunction

   // 1x1 into 1x1: the window is the pixel itself
   function automatic void add_identity(logic [31:0] rgba);
      step_row s;
      s = '{default: '0};
      s.px    = rgba;
      s.typed = 1'b1;
      s.want  = '{7'd0, 7'd0, rgba[31:24], rgba[23:16], rgba[15:8], rgba[7:0], 1'b1};
      directed_steps.push_back(s);
   endfunction

   function automatic pixel_type random_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return pixel_type'($urandom);
      endcase
   endfunction

   // receiver: ready runs in stretches of always-on, coin flips and stalls
   int ready_mode, ready_left;
   always @(posedge clock) begin
      if (ready_left <= 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_left <= (ready_mode == 2) ? $urandom_range(1, 12) : $urandom_range(5, 40);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_windows.size() == 0) begin
            $error("unexpected result beat col %0d row %0d", rsp_data.out_column,
                   rsp_data.out_row);
            failed = 1'b1;
         end else begin
            want = expected_windows.pop_front();
            if (rsp_data.out_column !== want.out_column) begin
               $error("out_column: expected %0d, actual %0d", want.out_column,
                      rsp_data.out_column);
               failed = 1'b1;
            end
            if (rsp_data.out_row !== want.out_row) begin
               $error("out_row: expected %0d, actual %0d", want.out_row, rsp_data.out_row);
               failed = 1'b1;
            end
            if (rsp_data.out_red !== want.out_red) begin
               $error("out_red: expected %0d, actual %0d", want.out_red, rsp_data.out_red);
               failed = 1'b1;
            end
            if (rsp_data.out_green !== want.out_green) begin
               $error("out_green: expected %0d, actual %0d", want.out_green,
                      rsp_data.out_green);
               failed = 1'b1;
            end
            if (rsp_data.out_blue !== want.out_blue) begin
               $error("out_blue: expected %0d, actual %0d", want.out_blue, rsp_data.out_blue);
               failed = 1'b1;
            end
            if (rsp_data.out_alpha !== want.out_alpha) begin
               $error("out_alpha: expected %0d, actual %0d", want.out_alpha,
                      rsp_data.out_alpha);
               failed = 1'b1;
            end
            if (rsp_data.run_end !== want.run_end) begin
               $error("run_end: expected %0d, actual %0d", want.run_end, rsp_data.run_end);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      int unsigned sw, sh, dw, dh, count, sent;

      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      rsp_ready  <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      ready_mode = 0;
      ready_left = 0;
      failed     = 1'b0;
      burst_left = 0;
      for (int i = 0; i < 4; i++) size_regs[i] = 1;
      src_col = 0;
      src_row = 0;
      for (int i = 0; i < 2*MAX_TARGET_DIM; i++) begin
         for (int k = 0; k < CHANNELS; k++) chan_sums[k][i] = 0;
         pix_counts[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: every pixel is its own window
      add_identity(32'h0000_0000);
      add_identity(32'hFFFF_FFFF);
      add_identity(32'h1234_5678);
      // 2x2 into 2x2: shared borders, last pixel closes four windows, then wrap
      add_write(REG_SOURCE_WIDTH, 14'd2);
      add_write(REG_SOURCE_HEIGHT, 14'd2);
      add_write(REG_TARGET_WIDTH, 14'd2);
      add_write(REG_TARGET_HEIGHT, 14'd2);
      add_pixel(32'hFFFF_FFFF);
      add_pixel(32'h0000_0000);
      add_pixel(32'hFFFF_FFFF);
      add_pixel(32'h0101_0101);
      add_pixel(32'hA5A5_5A5A);
      // target 0 acts as 1, target above source clamps; spare index is ignored
      add_write(REG_TARGET_WIDTH, 14'd0);
      add_write(REG_TARGET_HEIGHT, 14'd255);
      add_write(REG_SPARE_LOW, 14'h3FFF);
      add_pixel(32'h8080_8080);
      add_pixel(32'h7F7F_7F7F);
      add_pixel(32'hFF00_FF00);
      add_pixel(32'h00FF_00FF);
      // source 0 acts as 1, oversize source clamps
      add_write(REG_SOURCE_WIDTH, 14'd0);
      add_write(REG_SOURCE_HEIGHT, 14'h3FFF);
      add_write(REG_TARGET_WIDTH, 14'd255);
      add_write(REG_TARGET_HEIGHT, 14'd0);
      add_pixel(32'hFFFF_FFFF);
      add_pixel(32'hFFFF_FFFF);
      add_pixel(32'h0000_0000);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_write) begin
            settle();
            write_reg(directed_steps[i].index, directed_steps[i].value);
         end else begin
            send_pixel(directed_steps[i].px, !directed_steps[i].typed);
            if (directed_steps[i].typed) expected_windows.push_back(directed_steps[i].want);
         end
      end

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         if ($urandom_range(0, 9) == 0) begin
            // wide frame: windows of about 64 columns, results are sparse
            case ($urandom_range(0, 2))
               0: sw = MAX_SOURCE_DIM;
               1: sw = 16383;
               default: sw = MAX_SOURCE_DIM - 1;
            endcase
            sh    = $urandom_range(1, 3);
            dw    = $urandom_range(0, 1) ? MAX_TARGET_DIM : 255;
            dh    = $urandom_range(0, 4);
            count = $urandom_range(150, 260);
         end else begin
            sw    = $urandom_range(1, 10);
            sh    = $urandom_range(1, 10);
            dw    = $urandom_range(0, sw + 2);
            dh    = $urandom_range(0, sh + 2);
            count = sw * sh * $urandom_range(1, 2) + $urandom_range(0, 5);
            if (count > 80) count = 80;
         end
         if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;
         configure(sw, sh, dw, dh);
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_INDEX_W'($urandom_range(REG_SPARE_LOW, REG_SPARE_HIGH)),
                      CSR_DATA_W'($urandom));
         repeat (count) send_pixel(random_pixel(), 1'b1);
         sent += count;
      end

      settle();
      if (!failed && expected_windows.size() == 0) begin
         $display("rgba_box_filter_downscaler regression: pass");
      end else begin
         $display("rgba_box_filter_downscaler regression: fail");
      end
      $finish;
   end

endmodule
